[rtl/erv_pkg.sv]
`timescale 1ns / 1ps

package erv_pkg;

   localparam int COORD_WIDTH     = 24;
   localparam int COEF_WIDTH      = 18;
   localparam int COEF_FRAC       = COEF_WIDTH - 2;
   localparam int ANGLE_WIDTH     = 14;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = ANGLE_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_X = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_Y = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_Z = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;
   typedef coef_type [8:0]                coef_mat_type;

   typedef struct packed {
      logic                       we;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  wdata;
   } csr_write_type;

   localparam coef_type COEF_ONE = COEF_WIDTH'(1 << COEF_FRAC);

   function automatic coef_mat_type identity_mat();
      coef_mat_type m;
      m    = '0;
      m[0] = COEF_ONE;
      m[4] = COEF_ONE;
      m[8] = COEF_ONE;
      return m;
   endfunction

endpackage

[rtl/erv_req_if.sv]
`timescale 1ns / 1ps

interface erv_req_if import erv_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type x_in;
   coord_type y_in;
   coord_type z_in;
   coord_type w_in;
   logic      last_in;

   modport source (output valid, output x_in, output y_in, output z_in, output w_in,
                   output last_in, input ready);
   modport sink   (input valid, input x_in, input y_in, input z_in, input w_in,
                   input last_in, output ready);
endinterface

[rtl/erv_rsp_if.sv]
`timescale 1ns / 1ps

interface erv_rsp_if import erv_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type x_out;
   coord_type y_out;
   coord_type z_out;
   coord_type w_out;
   logic      last_out;

   modport source (output valid, output x_out, output y_out, output z_out, output w_out,
                   output last_out, input ready);
   modport sink   (input valid, input x_out, input y_out, input z_out, input w_out,
                   input last_out, output ready);
endinterface

[rtl/erv_coef_build.sv]
`timescale 1ns / 1ps

module erv_coef_build import erv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   output logic          busy,
   output coef_mat_type  coef
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RED  = 4'd1;
   localparam logic [3:0] ST_X    = 4'd2;
   localparam logic [3:0] ST_X2   = 4'd3;
   localparam logic [3:0] ST_XW   = 4'd4;
   localparam logic [3:0] ST_MP   = 4'd5;
   localparam logic [3:0] ST_P    = 4'd6;
   localparam logic [3:0] ST_Q    = 4'd7;
   localparam logic [3:0] ST_SM   = 4'd8;
   localparam logic [3:0] ST_S    = 4'd9;
   localparam logic [3:0] ST_FIN  = 4'd10;
   localparam logic [3:0] ST_MA   = 4'd11;
   localparam logic [3:0] ST_MB   = 4'd12;

   localparam logic [3:0] SIN_FIRST = 4'd0;
   localparam logic [3:0] SIN_LAST  = 4'd4;
   localparam logic [3:0] COS_FIRST = 4'd5;
   localparam logic [3:0] COS_LAST  = 4'd10;

   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;

   localparam logic [1:0] LAST_POS = 2'd2;
   localparam logic [1:0] LAST_AXIS = 2'd2;

   localparam logic signed [ANGLE_WIDTH:0] FULL_TURN = 5760;
   localparam logic [12:0] TURN_1Q = 13'd1440;
   localparam logic [12:0] TURN_2Q = 13'd2880;
   localparam logic [12:0] TURN_3Q = 13'd4320;
   localparam logic [10:0] QUARTER = 11'd1440;
   localparam logic [10:0] EIGHTH  = 11'd720;

   localparam logic [30:0] STEP_Q30 = 31'd1171271;
   localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
   localparam int          TRIG_SH  = 30 - COEF_FRAC;

   localparam logic [7:0] SERIES_K [11] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
                                            8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
   localparam logic [30:0] SERIES_M [11] = '{
      31'((64'd1 << 31) / 110), 31'((64'd1 << 31) / 72), 31'((64'd1 << 31) / 42),
      31'((64'd1 << 31) / 20),  31'((64'd1 << 31) / 6),  31'((64'd1 << 31) / 132),
      31'((64'd1 << 31) / 90),  31'((64'd1 << 31) / 56), 31'((64'd1 << 31) / 30),
      31'((64'd1 << 31) / 12),  31'((64'd1 << 31) / 2)};

   localparam int ACC_W = 2 * COEF_WIDTH + 2;
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1 << (COEF_FRAC - 1));
   localparam logic signed [ACC_W-1:0] ACC_CMAX = ACC_W'((1 << (COEF_WIDTH - 1)) - 1);
   localparam logic signed [ACC_W-1:0] ACC_CMIN = ACC_W'(-(1 << (COEF_WIDTH - 1)));

   function automatic coef_type round_q30(input logic [30:0] v);
      logic [31:0] sum;
      sum = {1'b0, v} + 32'(1 << (TRIG_SH - 1));
      return COEF_WIDTH'(sum >> TRIG_SH);
   endfunction

   function automatic coef_type rx_elem(input logic [3:0] i, input coef_type s,
                                        input coef_type c);
      coef_type e;
      case (i)
         4'd0:    e = COEF_ONE;
         4'd4:    e = c;
         4'd5:    e = s;
         4'd7:    e = -s;
         4'd8:    e = c;
         default: e = '0;
      endcase
      return e;
   endfunction

   function automatic coef_type ry_elem(input logic [3:0] i, input coef_type s,
                                        input coef_type c);
      coef_type e;
      case (i)
         4'd0:    e = c;
         4'd2:    e = -s;
         4'd4:    e = COEF_ONE;
         4'd6:    e = s;
         4'd8:    e = c;
         default: e = '0;
      endcase
      return e;
   endfunction

   function automatic coef_type rz_elem(input logic [3:0] i, input coef_type s,
                                        input coef_type c);
      coef_type e;
      case (i)
         4'd0:    e = c;
         4'd1:    e = s;
         4'd3:    e = -s;
         4'd4:    e = c;
         4'd8:    e = COEF_ONE;
         default: e = '0;
      endcase
      return e;
   endfunction

   logic [3:0]  state_ff, state_in;
   logic [1:0]  idx_ff, idx_in;
   angle_type   angle_ff [3];
   angle_type   angle_in [3];
   logic [9:0]  ro_ff, ro_in;
   logic [1:0]  quad_ff, quad_in;
   logic        swap_ff, swap_in;
   logic [61:0] mul_ff;
   logic [30:0] mul_a, mul_b;
   logic [29:0] x_ff, x_in;
   logic [29:0] x2_ff, x2_in;
   logic [30:0] t_ff, t_in;
   logic [29:0] p_ff, p_in;
   logic [29:0] s30_ff, s30_in;
   logic [3:0]  k_ff, k_in;
   coef_type    sin_ff [3];
   coef_type    sin_in [3];
   coef_type    cos_ff [3];
   coef_type    cos_in [3];
   logic        pass_ff, pass_in;
   logic [1:0]  row_ff, row_in;
   logic [1:0]  col_ff, col_in;
   logic [1:0]  term_ff, term_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [2*COEF_WIDTH-1:0] prodm_ff, prodm_in;
   coef_mat_type tmp_ff, tmp_in;
   coef_mat_type coef_ff, coef_in;

   // working values
   angle_type                red_a;
   logic signed [ANGLE_WIDTH:0] red_w;
   logic [12:0]              red_t;
   logic [10:0]              red_r;
   logic [1:0]               red_q;
   logic [29:0]              div_q0;
   logic [37:0]              div_qk;
   logic [37:0]              div_rem;
   logic [29:0]              div_q;
   logic [30:0]              fin_s, fin_c;
   coef_type                 sv, cv;
   logic [3:0]               a_idx, b_idx, e_idx;
   coef_type                 op_a, op_b;
   logic signed [ACC_W-1:0]  acc_sum;
   logic signed [ACC_W-1:0]  acc_shr;
   coef_type                 entry;

   always_comb begin
      case (state_ff)
         ST_X: begin
            mul_a = {21'b0, ro_ff};
            mul_b = STEP_Q30;
         end
         ST_X2: begin
            mul_a = {1'b0, mul_ff[29:0]};
            mul_b = {1'b0, mul_ff[29:0]};
         end
         ST_MP: begin
            mul_a = {1'b0, x2_ff};
            mul_b = t_ff;
         end
         ST_P: begin
            mul_a = {1'b0, mul_ff[59:30]};
            mul_b = SERIES_M[k_ff];
         end
         ST_SM: begin
            mul_a = {1'b0, x_ff};
            mul_b = t_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      // angle reduction into one quadrant and a remainder within that quadrant
      red_a = angle_ff[idx_ff];
      red_w = {red_a[ANGLE_WIDTH-1], red_a};
      if (red_w < 0) begin
         red_w = red_w + FULL_TURN;
         if (red_w < 0) begin
            red_w = red_w + FULL_TURN;
         end
      end else if (red_w >= FULL_TURN) begin
         red_w = red_w - FULL_TURN;
      end
      red_t = red_w[12:0];
      if (red_t >= TURN_3Q) begin
         red_q = 2'd3;
         red_r = 11'(red_t - TURN_3Q);
      end else if (red_t >= TURN_2Q) begin
         red_q = 2'd2;
         red_r = 11'(red_t - TURN_2Q);
      end else if (red_t >= TURN_1Q) begin
         red_q = 2'd1;
         red_r = 11'(red_t - TURN_1Q);
      end else begin
         red_q = 2'd0;
         red_r = 11'(red_t);
      end

      // reciprocal quotient is at most one short
      div_q0  = mul_ff[60:31];
      div_qk  = {8'b0, div_q0} * {30'b0, SERIES_K[k_ff]};
      div_rem = {8'b0, p_ff} - div_qk;
      div_q   = (div_rem >= {30'b0, SERIES_K[k_ff]}) ? div_q0 + 30'd1 : div_q0;

      if (swap_ff) begin
         fin_s = t_ff;
         fin_c = {1'b0, s30_ff};
      end else begin
         fin_s = {1'b0, s30_ff};
         fin_c = t_ff;
      end
      sv = round_q30(fin_s);
      cv = round_q30(fin_c);

      a_idx = 4'(3 * int'(row_ff) + int'(term_ff));
      b_idx = 4'(3 * int'(term_ff) + int'(col_ff));
      e_idx = 4'(3 * int'(row_ff) + int'(col_ff));
      if (!pass_ff) begin
         op_a = rx_elem(a_idx, sin_ff[0], cos_ff[0]);
         op_b = ry_elem(b_idx, sin_ff[1], cos_ff[1]);
      end else begin
         op_a = $signed(tmp_ff[a_idx]);
         op_b = rz_elem(b_idx, sin_ff[2], cos_ff[2]);
      end

      acc_sum = acc_ff + ACC_W'(prodm_ff);
      acc_shr = acc_sum >>> COEF_FRAC;
      if (acc_shr > ACC_CMAX) begin
         entry = COEF_WIDTH'(ACC_CMAX);
      end else if (acc_shr < ACC_CMIN) begin
         entry = COEF_WIDTH'(ACC_CMIN);
      end else begin
         entry = COEF_WIDTH'(acc_shr);
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      angle_in = angle_ff;
      ro_in    = ro_ff;
      quad_in  = quad_ff;
      swap_in  = swap_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      t_in     = t_ff;
      p_in     = p_ff;
      s30_in   = s30_ff;
      k_in     = k_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      pass_in  = pass_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      term_in  = term_ff;
      acc_in   = acc_ff;
      prodm_in = op_a * op_b;
      tmp_in   = tmp_ff;
      coef_in  = coef_ff;

      case (state_ff)
         ST_RED: begin
            quad_in = red_q;
            if (red_r <= EIGHTH) begin
               ro_in   = red_r[9:0];
               swap_in = 1'b0;
            end else begin
               ro_in   = 10'(QUARTER - red_r);
               swap_in = 1'b1;
            end
            state_in = ST_X;
         end
         ST_X: begin
            state_in = ST_X2;
         end
         ST_X2: begin
            x_in     = mul_ff[29:0];
            state_in = ST_XW;
         end
         ST_XW: begin
            x2_in    = mul_ff[59:30];
            t_in     = ONE_Q30;
            k_in     = SIN_FIRST;
            state_in = ST_MP;
         end
         ST_MP: begin
            state_in = ST_P;
         end
         ST_P: begin
            p_in     = mul_ff[59:30];
            state_in = ST_Q;
         end
         ST_Q: begin
            t_in = ONE_Q30 - {1'b0, div_q};
            if (k_ff == SIN_LAST) begin
               state_in = ST_SM;
            end else if (k_ff == COS_LAST) begin
               state_in = ST_FIN;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = ST_MP;
            end
         end
         ST_SM: begin
            state_in = ST_S;
         end
         ST_S: begin
            s30_in   = mul_ff[59:30];
            t_in     = ONE_Q30;
            k_in     = COS_FIRST;
            state_in = ST_MP;
         end
         ST_FIN: begin
            case (quad_ff)
               QUAD_I: begin
                  sin_in[idx_ff] = sv;
                  cos_in[idx_ff] = cv;
               end
               QUAD_II: begin
                  sin_in[idx_ff] = cv;
                  cos_in[idx_ff] = -sv;
               end
               QUAD_III: begin
                  sin_in[idx_ff] = -sv;
                  cos_in[idx_ff] = -cv;
               end
               default: begin
                  sin_in[idx_ff] = -cv;
                  cos_in[idx_ff] = sv;
               end
            endcase
            if (idx_ff == LAST_AXIS) begin
               pass_in  = 1'b0;
               row_in   = '0;
               col_in   = '0;
               term_in  = '0;
               acc_in   = ACC_HALF;
               state_in = ST_MA;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_RED;
            end
         end
         ST_MA: begin
            state_in = ST_MB;
         end
         ST_MB: begin
            state_in = ST_MA;
            if (term_ff == LAST_POS) begin
               if (!pass_ff) begin
                  tmp_in[e_idx] = entry;
               end else begin
                  coef_in[e_idx] = entry;
               end
               acc_in  = ACC_HALF;
               term_in = '0;
               if (col_ff == LAST_POS) begin
                  col_in = '0;
                  if (row_ff == LAST_POS) begin
                     row_in = '0;
                     if (pass_ff) begin
                        state_in = ST_IDLE;
                     end
                     pass_in = 1'b1;
                  end else begin
                     row_in = row_ff + 2'd1;
                  end
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end else begin
               acc_in  = acc_sum;
               term_in = term_ff + 2'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // any angle register write restarts the rebuild from the first axis
      if (csr.we) begin
         case (csr.index)
            CSR_ANGLE_X: begin
               angle_in[0] = csr.wdata;
               idx_in      = '0;
               state_in    = ST_RED;
            end
            CSR_ANGLE_Y: begin
               angle_in[1] = csr.wdata;
               idx_in      = '0;
               state_in    = ST_RED;
            end
            CSR_ANGLE_Z: begin
               angle_in[2] = csr.wdata;
               idx_in      = '0;
               state_in    = ST_RED;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         angle_ff <= '{default: '0};
         coef_ff  <= identity_mat();
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         angle_ff <= angle_in;
         coef_ff  <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff   <= {31'b0, mul_a} * {31'b0, mul_b};
      ro_ff    <= ro_in;
      quad_ff  <= quad_in;
      swap_ff  <= swap_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      t_ff     <= t_in;
      p_ff     <= p_in;
      s30_ff   <= s30_in;
      k_ff     <= k_in;
      sin_ff   <= sin_in;
      cos_ff   <= cos_in;
      pass_ff  <= pass_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      term_ff  <= term_in;
      acc_ff   <= acc_in;
      prodm_ff <= prodm_in;
      tmp_ff   <= tmp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign coef = coef_ff;

endmodule

[rtl/euler_rotation_vertex_transform.sv]
`timescale 1ns / 1ps
// Vertex beats pass the input, product and output stages in turn, at one vertex
// per cycle while no rebuild runs; rsp back-pressure fills the stages first.
// An angle register write rebuilds the matrix on one shared 31x31 multiplier and
// one 18x18 multiplier, with req ready held low throughout.
// Reset (synchronous): angles zero, matrix identity, pipeline empty, ready at once.
module euler_rotation_vertex_transform import erv_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   erv_req_if.sink                    req_ch,
   erv_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
   localparam int SUM_W  = PROD_W + 2;
   localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1 << (COEF_FRAC - 1));
   localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'((1 << (COORD_WIDTH - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SUM_MIN  = SUM_W'(-(1 << (COORD_WIDTH - 1)));

   csr_write_type csr;
   logic          busy;
   coef_mat_type  coef;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   erv_coef_build u_build (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .busy  (busy),
      .coef  (coef)
   );

   logic      in_v_ff, in_v_in;
   coord_type vin_ff [3];
   coord_type vin_in [3];
   coord_type w_ff, w_in;
   logic      last_ff, last_in;

   logic                    prod_v_ff, prod_v_in;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   coord_type               w_p_ff, w_p_in;
   logic                    last_p_ff, last_p_in;

   logic      out_v_ff, out_v_in;
   coord_type vout_ff [3];
   coord_type vout_in [3];
   coord_type w_o_ff, w_o_in;
   logic      last_o_ff, last_o_in;

   logic in_adv, prod_adv, out_adv, accept;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] shr;

   assign out_adv  = !out_v_ff || rsp_ch.ready;
   assign prod_adv = !prod_v_ff || out_adv;
   assign in_adv   = !in_v_ff || prod_adv;
   assign req_ch.ready = in_adv && !busy;
   assign accept   = req_ch.valid && req_ch.ready;

   always_comb begin
      in_v_in   = in_v_ff;
      vin_in    = vin_ff;
      w_in      = w_ff;
      last_in   = last_ff;
      prod_v_in = prod_v_ff;
      prod_in   = prod_ff;
      w_p_in    = w_p_ff;
      last_p_in = last_p_ff;
      out_v_in  = out_v_ff;
      vout_in   = vout_ff;
      w_o_in    = w_o_ff;
      last_o_in = last_o_ff;
      sum       = '0;
      shr       = '0;

      if (in_adv) begin
         in_v_in   = accept;
         vin_in[0] = req_ch.x_in;
         vin_in[1] = req_ch.y_in;
         vin_in[2] = req_ch.z_in;
         w_in      = req_ch.w_in;
         last_in   = req_ch.last_in;
      end

      if (prod_adv) begin
         prod_v_in = in_v_ff;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_in[i][j] = PROD_W'(vin_ff[i]) * PROD_W'($signed(coef[i * 3 + j]));
            end
         end
         w_p_in    = w_ff;
         last_p_in = last_ff;
      end

      if (out_adv) begin
         out_v_in = prod_v_ff;
         for (int j = 0; j < 3; j++) begin
            sum = SUM_W'(prod_ff[0][j]) + SUM_W'(prod_ff[1][j]) + SUM_W'(prod_ff[2][j])
                  + SUM_HALF;
            shr = sum >>> COEF_FRAC;
            if (shr > SUM_MAX) begin
               vout_in[j] = COORD_WIDTH'(SUM_MAX);
            end else if (shr < SUM_MIN) begin
               vout_in[j] = COORD_WIDTH'(SUM_MIN);
            end else begin
               vout_in[j] = COORD_WIDTH'(shr);
            end
         end
         w_o_in    = w_p_ff;
         last_o_in = last_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         in_v_ff   <= in_v_in;
         prod_v_ff <= prod_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      vin_ff    <= vin_in;
      w_ff      <= w_in;
      last_ff   <= last_in;
      prod_ff   <= prod_in;
      w_p_ff    <= w_p_in;
      last_p_ff <= last_p_in;
      vout_ff   <= vout_in;
      w_o_ff    <= w_o_in;
      last_o_ff <= last_o_in;
   end

   assign rsp_ch.valid    = out_v_ff;
   assign rsp_ch.x_out    = vout_ff[0];
   assign rsp_ch.y_out    = vout_ff[1];
   assign rsp_ch.z_out    = vout_ff[2];
   assign rsp_ch.w_out    = w_o_ff;
   assign rsp_ch.last_out = last_o_ff;

`ifndef SYNTHESIS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_v_ff)
      else $error("accepted beat did not enter the input stage");

   a_prod_holds: assert property (@(posedge clock) disable iff (reset)
      (prod_v_ff && !prod_adv) |=> prod_v_ff)
      else $error("stalled product stage lost its beat");

   a_reset_identity: assert property (@(posedge clock)
      $past(reset) |-> (!busy && coef == identity_mat()))
      else $error("matrix not identity or rebuild running after reset");
`endif

endmodule

[tb/rotation_checker.sv]
`timescale 1ns / 1ps

module rotation_checker import erv_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   erv_req_if                         req_mon,
   erv_rsp_if                         rsp_mon,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                         mismatch_count,
   output int                         vertices_outstanding,
   output int                         vertices_checked
);

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
      coord_type w;
      logic      last;
   } rotated_vertex_type;

   localparam int     FULL_TURN    = 5760;
   localparam int     QUARTER_TURN = 1440;
   localparam int     EIGHTH_TURN  = 720;
   localparam longint unsigned STEP_Q30 = 64'd1171271;
   localparam longint unsigned ONE_Q30  = 64'd1 << 30;

   angle_type          angle_x, angle_y, angle_z;
   longint             coef [9];
   rotated_vertex_type rotated_q [$];

   function automatic longint round_sat(longint acc, int frac, int width);
      longint r, hi, lo;
      r  = (acc + (longint'(1) <<< (frac - 1))) >>> frac;
      hi = (longint'(1) <<< (width - 1)) - 1;
      lo = -(longint'(1) <<< (width - 1));
      if (r > hi) return hi;
      if (r < lo) return lo;
      return r;
   endfunction

   // Taylor series in unsigned Q30 over the first half quadrant
   task automatic taylor_q30(input int r, output longint unsigned s, output longint unsigned c);
      longint unsigned x, x2, t;
      longint unsigned ks [5];
      longint unsigned kc [6];
      ks = '{110, 72, 42, 20, 6};
      kc = '{132, 90, 56, 30, 12, 2};
      x  = longint'(r) * STEP_Q30;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      foreach (ks[i]) t = ONE_Q30 - ((x2 * t) >> 30) / ks[i];
      s  = (x * t) >> 30;
      t  = ONE_Q30;
      foreach (kc[i]) t = ONE_Q30 - ((x2 * t) >> 30) / kc[i];
      c  = t;
   endtask

   task automatic angle_sin_cos(input angle_type a, output longint s, output longint c);
      int              am, q, r;
      longint unsigned s30, c30;
      longint          sv, cv;
      am = int'(a) % FULL_TURN;
      if (am < 0) am += FULL_TURN;
      q = am / QUARTER_TURN;
      r = am % QUARTER_TURN;
      if (r <= EIGHTH_TURN) taylor_q30(r, s30, c30);
      else taylor_q30(QUARTER_TURN - r, c30, s30);
      sv = longint'((s30 + (64'd1 << 13)) >> (30 - COEF_FRAC));
      cv = longint'((c30 + (64'd1 << 13)) >> (30 - COEF_FRAC));
      case (q)
         0: begin s = sv;  c = cv;  end
         1: begin s = cv;  c = -sv; end
         2: begin s = -sv; c = -cv; end
         default: begin s = -cv; c = sv; end
      endcase
   endtask

   task automatic mat_product(input longint a [9], input longint b [9], output longint p [9]);
      longint acc;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += a[r*3+k] * b[k*3+c];
            p[r*3+c] = round_sat(acc, COEF_FRAC, COEF_WIDTH);
         end
   endtask

   task automatic rebuild_matrix();
      longint sx, cx, sy, cy, sz, cz, one;
      longint mx [9], my [9], mz [9], tmp [9], res [9];
      one = longint'(1) <<< COEF_FRAC;
      angle_sin_cos(angle_x, sx, cx);
      angle_sin_cos(angle_y, sy, cy);
      angle_sin_cos(angle_z, sz, cz);
      mx = '{one, 0, 0, 0, cx, sx, 0, -sx, cx};
      my = '{cy, 0, -sy, 0, one, 0, sy, 0, cy};
      mz = '{cz, sz, 0, -sz, cz, 0, 0, 0, one};
      mat_product(mx, my, tmp);
      mat_product(tmp, mz, res);
      coef = res;
   endtask

   function automatic rotated_vertex_type rotate_vertex(coord_type x, coord_type y,
                                                        coord_type z, coord_type w,
                                                        logic last);
      rotated_vertex_type o;
      longint v [3];
      longint acc [3];
      v = '{longint'(x), longint'(y), longint'(z)};
      for (int j = 0; j < 3; j++) begin
         acc[j] = 0;
         for (int i = 0; i < 3; i++) acc[j] += v[i] * coef[i*3+j];
         acc[j] = round_sat(acc[j], COEF_FRAC, COORD_WIDTH);
      end
      o.x    = coord_type'(acc[0]);
      o.y    = coord_type'(acc[1]);
      o.z    = coord_type'(acc[2]);
      o.w    = w;
      o.last = last;
      return o;
   endfunction

   always @(posedge clock) begin
      rotated_vertex_type exp_v;
      if (reset) begin
         angle_x = '0;
         angle_y = '0;
         angle_z = '0;
         rebuild_matrix();
         rotated_q.delete();
         mismatch_count       = 0;
         vertices_checked     = 0;
         vertices_outstanding = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (rotated_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected rsp beat x=%0d y=%0d z=%0d w=%0d last=%0b", $realtime,
                        rsp_mon.x_out, rsp_mon.y_out, rsp_mon.z_out, rsp_mon.w_out,
                        rsp_mon.last_out);
            end else begin
               exp_v = rotated_q.pop_front();
               vertices_checked++;
               if (rsp_mon.x_out !== exp_v.x || rsp_mon.y_out !== exp_v.y ||
                   rsp_mon.z_out !== exp_v.z || rsp_mon.w_out !== exp_v.w ||
                   rsp_mon.last_out !== exp_v.last) begin
                  mismatch_count++;
                  $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d last=%0b", $realtime,
                           exp_v.x, exp_v.y, exp_v.z, exp_v.w, exp_v.last);
                  $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d last=%0b", $realtime,
                           rsp_mon.x_out, rsp_mon.y_out, rsp_mon.z_out, rsp_mon.w_out,
                           rsp_mon.last_out);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            rotated_q.push_back(rotate_vertex(req_mon.x_in, req_mon.y_in, req_mon.z_in,
                                              req_mon.w_in, req_mon.last_in));
         if (csr_we) begin
            case (csr_index)
               CSR_ANGLE_X: begin angle_x = angle_type'(csr_wdata); rebuild_matrix(); end
               CSR_ANGLE_Y: begin angle_y = angle_type'(csr_wdata); rebuild_matrix(); end
               CSR_ANGLE_Z: begin angle_z = angle_type'(csr_wdata); rebuild_matrix(); end
               default: ;
            endcase
         end
         vertices_outstanding = rotated_q.size();
      end
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import erv_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD  = 400;
   localparam coord_type CMAX = coord_type'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam coord_type CMIN = coord_type'({1'b1, {(COORD_WIDTH-1){1'b0}}});
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   int mismatch_count, vertices_outstanding, vertices_checked;
   int tx_idle_pct, rx_idle_pct;
   int hold_requests, hold_served, hold_left;
   int idle_cycles;
   int settings_used;

   erv_req_if req_ch ();
   erv_rsp_if rsp_ch ();

   euler_rotation_vertex_transform dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rotation_checker checker_i (
      .clock                (clock),
      .reset                (reset),
      .req_mon              (req_ch),
      .rsp_mon              (rsp_ch),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .vertices_outstanding (vertices_outstanding),
      .vertices_checked     (vertices_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // rsp ready: random idling plus an occasional long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      hold_served  = 0;
      hold_left    = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $realtime, IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_vertex(coord_type x, coord_type y, coord_type z, coord_type w,
                              logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.x_in    = x;
      req_ch.y_in    = y;
      req_ch.z_in    = z;
      req_ch.w_in    = w;
      req_ch.last_in = last;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid = 1'b0;
      while (vertices_outstanding != 0) @(negedge clock);
   endtask

   task automatic write_angle(logic [CSR_INDEX_WIDTH-1:0] idx, int value);
      drain();
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_WIDTH'(value);
      @(negedge clock);
      csr_we = 1'b0;
      @(negedge clock);
      // hold until the matrix rebuild lets req in again
      while (!req_ch.ready) @(negedge clock);
   endtask

   task automatic set_angles(int ax, int ay, int az);
      write_angle(CSR_ANGLE_X, ax);
      write_angle(CSR_ANGLE_Y, ay);
      write_angle(CSR_ANGLE_Z, az);
      settings_used++;
   endtask

   function automatic coord_type pick_coord();
      case ($urandom_range(3))
         0: return coord_type'($urandom);
         1: return coord_type'(int'($urandom_range(8191)) - 4096);
         2: return $urandom_range(1) ? CMAX : CMIN;
         default: return coord_type'($urandom) >>> $urandom_range(12);
      endcase
   endfunction

   function automatic int pick_angle();
      case ($urandom_range(3))
         0: return int'($urandom_range(11520)) - 5760;
         1: return int'(angle_type'($urandom));
         2: return $urandom_range(1) ? 5760 : -5760;
         default: return 720 * int'($urandom_range(16)) - 5760;
      endcase
   endfunction

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.x_in    = '0;
      req_ch.y_in    = '0;
      req_ch.z_in    = '0;
      req_ch.w_in    = '0;
      req_ch.last_in = 1'b0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      tx_idle_pct    = 0;
      rx_idle_pct    = 0;
      hold_requests  = 0;
      settings_used  = 0;
      reset          = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // identity after reset: extremes pass straight through
      send_vertex(CMAX, CMIN, 0, CMAX, 1'b0);
      send_vertex(CMIN, CMAX, CMIN, CMIN, 1'b1);
      send_vertex(0, 0, 0, 0, 1'b0);
      send_vertex(-1, 1, -1, 1, 1'b1);
      // quarter turn about z
      set_angles(0, 0, 1440);
      send_vertex(CMAX, CMIN, CMAX, 0, 1'b0);
      send_vertex(CMIN, CMIN, 256, -256, 1'b1);
      // eighth turns push large coordinates into saturation
      set_angles(720, -720, 720);
      send_vertex(CMAX, CMAX, CMAX, CMAX, 1'b0);
      send_vertex(CMIN, CMIN, CMIN, CMIN, 1'b1);
      send_vertex(CMAX, CMIN, 0, 7, 1'b0);
      send_vertex(1, 1, 1, 1, 1'b1);
      // full turns and beyond wrap round
      set_angles(5760, -5760, 8191);
      send_vertex(CMAX, 1000, -1000, 3, 1'b0);
      send_vertex(CMIN, -5, 5, -3, 1'b1);
      set_angles(-8192, 4000, -1);
      send_vertex(123456, -654321, 777, 9, 1'b1);
      send_vertex(CMAX, CMAX, CMIN, CMIN, 1'b0);
      // unused index leaves the matrix alone
      write_angle(CSR_UNUSED, 1440);
      send_vertex(5000, 6000, -7000, 8, 1'b1);
      send_vertex(CMIN, CMAX, CMAX, CMAX, 1'b0);

      for (int phase = 0; phase < 10; phase++) begin
         if (phase < 4) begin tx_idle_pct = 17; rx_idle_pct = 77; end
         else if (phase < 7) begin tx_idle_pct = 77; rx_idle_pct = 17; end
         else begin tx_idle_pct = 0; rx_idle_pct = 0; end
         case (phase)
            0: set_angles(0, 0, 0);
            1: set_angles(5760, -5760, 0);
            2: set_angles(-8192, 8191, 1);
            default: set_angles(pick_angle(), pick_angle(), pick_angle());
         endcase
         if (phase == 2 || phase == 8) hold_requests++;
         for (int n = 0; n < 150; n++) begin
            if (n == 75) drain();
            send_vertex(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        1'($urandom_range(1)));
         end
      end

      drain();
      repeat (20) @(negedge clock);
      $display("covered %0d vertices over %0d angle settings, incl. wrap, saturation and stalls",
               vertices_checked, settings_used);
      if (mismatch_count == 0 && vertices_outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
